// ===== rtl/rgbfx_pkg.sv =====
// Shared types and constants of the RGB LED effect engine.
`default_nettype none
package rgbfx_pkg;

	localparam int unsigned ChanW    = 8;
	localparam int unsigned ProdW    = 2 * ChanW;
	localparam int unsigned CountW   = 9;
	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned InDataW  = 16;
	localparam int unsigned OutDataW = 32;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_ON      = 3'd1,
		OP_OFF     = 3'd2,
		OP_BLINK   = 3'd3,
		OP_RAINBOW = 3'd4,
		OP_BREATHE = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		MODE_NONE    = 2'd0,
		MODE_BLINK   = 2'd1,
		MODE_RAINBOW = 2'd2,
		MODE_BREATHE = 2'd3
	} mode_t;

	localparam logic [CfgIdxW-1:0] CFG_RED    = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_GREEN  = 8'd1;
	localparam logic [CfgIdxW-1:0] CFG_BLUE   = 8'd2;
	localparam logic [CfgIdxW-1:0] CFG_BRIGHT = 8'd3;

	// What the multiplier sequence has to produce for the current transaction
	typedef enum logic [2:0] {
		SC_NONE    = 3'd0,
		SC_BLACK   = 3'd1,
		SC_COLOUR  = 3'd2,
		SC_ON      = 3'd3,
		SC_WHEEL   = 3'd4,
		SC_BREATHE = 3'd5
	} scale_t;

	localparam logic [ChanW-1:0] BRIGHT_RESET  = 8'd16;
	localparam logic [ChanW-1:0] HUE_STEP      = 8'd4;
	localparam logic [ChanW-1:0] BREATHE_STEP  = 8'd5;
	localparam logic [ChanW-1:0] BREATHE_TOP   = 8'd250;
	localparam logic [ChanW-1:0] CHAN_MAX      = 8'd255;
	localparam logic [ChanW-1:0] WHEEL_THIRD   = 8'd85;
	localparam logic [ChanW-1:0] WHEEL_2THIRD  = 8'd170;

	// Multiply step 0 forms the breathe factor, steps 1 to 3 scale red, green, blue
	localparam logic [1:0] STEP_FACTOR = 2'd0;
	localparam logic [1:0] STEP_RED    = 2'd1;
	localparam logic [1:0] STEP_GREEN  = 2'd2;
	localparam logic [1:0] STEP_BLUE   = 2'd3;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       store;
		logic [1:0] step;
	} cmd_t;

	typedef struct packed {
		logic need_scale;
		logic breathe;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/rgbfx_ctrl.sv =====
// Sequencer of the RGB LED effect engine: handshakes and multiply steps.
`default_nettype none
module rgbfx_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	input  wire rgbfx_pkg::sts_t sts,
	output rgbfx_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] step_q, step_d;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign accept   = s_tvalid && s_tready;

	assign cmd.load  = accept;
	assign cmd.mul   = (state_q == ST_MUL);
	assign cmd.store = (state_q == ST_DIV);
	assign cmd.step  = step_q;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// the status reflects the transaction latched at this edge
					state_d = ST_MUL;
					step_d  = rgbfx_pkg::STEP_FACTOR;
				end
			end
			ST_MUL: begin
				if (!sts.need_scale) begin
					state_d = ST_OUT;
				end else if (!sts.breathe && step_q == rgbfx_pkg::STEP_FACTOR) begin
					// no factor to form: skip straight to red
					step_d = rgbfx_pkg::STEP_RED;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == rgbfx_pkg::STEP_BLUE) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_MUL;
					step_d  = step_q + 2'd1;
				end
			end
			ST_OUT: begin
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= rgbfx_pkg::STEP_FACTOR;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rgbfx_dp.sv =====
// Datapath of the RGB LED effect engine: registers, effect state, shared scaler.
`default_nettype none
module rgbfx_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [rgbfx_pkg::CfgIdxW-1:0]        cfg_index,
	input  wire  [rgbfx_pkg::ChanW-1:0]          cfg_data,
	input  wire  [2:0]                           in_opcode,
	input  wire  [rgbfx_pkg::ChanW-1:0]          in_blink_times,
	input  wire                                  in_repeat_forever,
	input  wire  rgbfx_pkg::cmd_t                cmd,
	output rgbfx_pkg::sts_t                      sts,
	output logic [rgbfx_pkg::ChanW-1:0]          red_out,
	output logic [rgbfx_pkg::ChanW-1:0]          green_out,
	output logic [rgbfx_pkg::ChanW-1:0]          blue_out,
	output logic                                 pixel_update,
	output logic [1:0]                           effect_mode
);

	localparam int unsigned W = rgbfx_pkg::ChanW;

	// value * 255 fits in 16 bits; (x + x/256 + 1) / 256 equals x / 255 there
	function automatic logic [W-1:0] div255(input logic [rgbfx_pkg::ProdW-1:0] x);
		logic [rgbfx_pkg::ProdW:0] sum;
		sum = {1'b0, x} + {{(W+1){1'b0}}, x[rgbfx_pkg::ProdW-1:W]} +
			{{rgbfx_pkg::ProdW{1'b0}}, 1'b1};
		return sum[rgbfx_pkg::ProdW-1:W];
	endfunction

	function automatic logic [W-1:0] times3(input logic [W-1:0] v);
		logic [W+1:0] t;
		t = {2'b00, v} + {1'b0, v, 1'b0};
		return t[W-1:0];
	endfunction

	logic [W-1:0]                    red_q, green_q, blue_q, bright_q;
	rgbfx_pkg::mode_t                mode_q;
	logic [rgbfx_pkg::CountW-1:0]    hpc_q;
	logic                            endless_q;
	logic [W-1:0]                    hue_q;
	logic                            rising_q;
	logic [W-1:0]                    level_q;
	logic                            cyan_on_q;
	logic [W-1:0]                    cyan_lvl_q;
	rgbfx_pkg::scale_t               sel_q;
	logic                            upd_q;
	logic [W-1:0]                    fac_q, rch_q, gch_q, bch_q;
	logic [rgbfx_pkg::ProdW-1:0]     prod_q;

	logic [W-1:0] cr, cg, cb;
	logic         colour_nz;
	logic [W-1:0] p, q, wr, wg, wb;
	logic [W-1:0] mul_a, mul_b, chan_in;
	logic [W-1:0] quot;
	logic [rgbfx_pkg::CountW-1:0] hpc_dec;
	logic         on_fix;

	// effective colour: cyan override replaces the base registers
	always_comb begin
		if (cyan_on_q) begin
			cr = '0;
			cg = cyan_lvl_q;
			cb = cyan_lvl_q;
		end else begin
			cr = red_q;
			cg = green_q;
			cb = blue_q;
		end
	end
	assign colour_nz = (cr != '0) || (cg != '0) || (cb != '0);

	// colour wheel at the current hue, before brightness
	always_comb begin
		p  = ~hue_q;
		q  = p;
		wr = '0;
		wg = '0;
		wb = '0;
		if (p < rgbfx_pkg::WHEEL_THIRD) begin
			wr = rgbfx_pkg::CHAN_MAX - times3(p);
			wb = times3(p);
		end else if (p < rgbfx_pkg::WHEEL_2THIRD) begin
			q  = p - rgbfx_pkg::WHEEL_THIRD;
			wg = times3(q);
			wb = rgbfx_pkg::CHAN_MAX - times3(q);
		end else begin
			q  = p - rgbfx_pkg::WHEEL_2THIRD;
			wr = times3(q);
			wg = rgbfx_pkg::CHAN_MAX - times3(q);
		end
	end

	always_comb begin
		case (cmd.step)
			rgbfx_pkg::STEP_RED:   chan_in = (sel_q == rgbfx_pkg::SC_WHEEL) ? wr : cr;
			rgbfx_pkg::STEP_GREEN: chan_in = (sel_q == rgbfx_pkg::SC_WHEEL) ? wg : cg;
			rgbfx_pkg::STEP_BLUE:  chan_in = (sel_q == rgbfx_pkg::SC_WHEEL) ? wb : cb;
			default:               chan_in = bright_q;
		endcase
	end

	always_comb begin
		if (cmd.step == rgbfx_pkg::STEP_FACTOR) begin
			mul_a = bright_q;
			mul_b = level_q;
		end else begin
			mul_a = chan_in;
			mul_b = (sel_q == rgbfx_pkg::SC_BREATHE) ? fac_q : bright_q;
		end
	end

	assign quot    = div255(prod_q);
	assign hpc_dec = hpc_q - {{(rgbfx_pkg::CountW-1){1'b0}}, 1'b1};

	assign sts.need_scale = (sel_q != rgbfx_pkg::SC_NONE) && (sel_q != rgbfx_pkg::SC_BLACK);
	assign sts.breathe    = (sel_q == rgbfx_pkg::SC_BREATHE);

	// configuration and effect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q      <= '0;
			green_q    <= '0;
			blue_q     <= '0;
			bright_q   <= rgbfx_pkg::BRIGHT_RESET;
			mode_q     <= rgbfx_pkg::MODE_NONE;
			hpc_q      <= '0;
			endless_q  <= 1'b0;
			hue_q      <= '0;
			rising_q   <= 1'b1;
			level_q    <= '0;
			cyan_on_q  <= 1'b0;
			cyan_lvl_q <= '0;
			sel_q      <= rgbfx_pkg::SC_NONE;
			upd_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rgbfx_pkg::CFG_RED: begin
						red_q     <= cfg_data;
						cyan_on_q <= 1'b0;
					end
					rgbfx_pkg::CFG_GREEN: begin
						green_q   <= cfg_data;
						cyan_on_q <= 1'b0;
					end
					rgbfx_pkg::CFG_BLUE: begin
						blue_q    <= cfg_data;
						cyan_on_q <= 1'b0;
					end
					rgbfx_pkg::CFG_BRIGHT: begin
						bright_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				sel_q <= rgbfx_pkg::SC_NONE;
				upd_q <= 1'b0;
				case (in_opcode)
					rgbfx_pkg::OP_TICK: begin
						case (mode_q)
							rgbfx_pkg::MODE_BLINK: begin
								hpc_q <= hpc_dec;
								upd_q <= 1'b1;
								if (hpc_dec[0]) begin
									sel_q <= rgbfx_pkg::SC_COLOUR;
								end else begin
									sel_q <= rgbfx_pkg::SC_BLACK;
									if (hpc_dec == '0 && !endless_q) begin
										mode_q <= rgbfx_pkg::MODE_NONE;
									end
								end
							end
							rgbfx_pkg::MODE_RAINBOW: begin
								hue_q <= hue_q + rgbfx_pkg::HUE_STEP;
								sel_q <= rgbfx_pkg::SC_WHEEL;
								upd_q <= 1'b1;
							end
							rgbfx_pkg::MODE_BREATHE: begin
								// turn at the top and bottom, holding the level for that tick
								if (rising_q) begin
									if (level_q >= rgbfx_pkg::BREATHE_TOP) begin
										rising_q <= 1'b0;
									end else begin
										level_q <= level_q + rgbfx_pkg::BREATHE_STEP;
									end
								end else begin
									if (level_q <= rgbfx_pkg::BREATHE_STEP) begin
										rising_q <= 1'b1;
									end else begin
										level_q <= level_q - rgbfx_pkg::BREATHE_STEP;
									end
								end
								sel_q <= rgbfx_pkg::SC_BREATHE;
								upd_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
					rgbfx_pkg::OP_ON: begin
						mode_q <= rgbfx_pkg::MODE_NONE;
						sel_q  <= rgbfx_pkg::SC_ON;
						upd_q  <= 1'b1;
					end
					rgbfx_pkg::OP_OFF: begin
						mode_q <= rgbfx_pkg::MODE_NONE;
						sel_q  <= rgbfx_pkg::SC_BLACK;
						upd_q  <= 1'b1;
					end
					rgbfx_pkg::OP_BLINK: begin
						mode_q    <= rgbfx_pkg::MODE_BLINK;
						hpc_q     <= {in_blink_times, 1'b0};
						endless_q <= in_repeat_forever || (in_blink_times == '0);
					end
					rgbfx_pkg::OP_RAINBOW: begin
						mode_q <= rgbfx_pkg::MODE_RAINBOW;
						hue_q  <= '0;
					end
					rgbfx_pkg::OP_BREATHE: begin
						mode_q   <= rgbfx_pkg::MODE_BREATHE;
						rising_q <= 1'b1;
						level_q  <= '0;
						if (!colour_nz) begin
							cyan_on_q  <= 1'b1;
							cyan_lvl_q <= bright_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// product and quotient registers of the shared scaler
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rch_q <= '0;
			gch_q <= '0;
			bch_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
		end
		if (cmd.store) begin
			case (cmd.step)
				rgbfx_pkg::STEP_RED:   rch_q <= quot;
				rgbfx_pkg::STEP_GREEN: gch_q <= quot;
				rgbfx_pkg::STEP_BLUE:  bch_q <= quot;
				default:               fac_q <= quot;
			endcase
		end
	end

	// turn on never blanks a lit colour at nonzero brightness
	assign on_fix = (sel_q == rgbfx_pkg::SC_ON) && colour_nz && (bright_q != '0) &&
			(rch_q == '0) && (gch_q == '0) && (bch_q == '0);

	always_comb begin
		if (on_fix) begin
			red_out   = {{(W-1){1'b0}}, (cr != '0)};
			green_out = {{(W-1){1'b0}}, (cg != '0)};
			blue_out  = {{(W-1){1'b0}}, (cb != '0)};
		end else begin
			red_out   = rch_q;
			green_out = gch_q;
			blue_out  = bch_q;
		end
	end

	assign pixel_update = upd_q;
	assign effect_mode  = mode_q;

endmodule
`default_nettype wire

// ===== rtl/rgb_led_effect_engine.sv =====
// Top level of the RGB LED effect engine.
//
// Commands enter on the s_ stream: opcode in s_tuser, blink count and repeat flag in
// s_tdata. Every command gives exactly one pixel transaction on the m_ stream with
// the colour in m_tdata and the write flag in m_tuser; when no write is flagged the
// colour is zero. Base colour and brightness are written on the cfg_ channel, which
// is always ready; an index above 3 is dropped. The user is to use it only while the
// engine is idle; the engine itself does not enforce this.
// One command is in flight at a time. The result of a command that writes no scaled
// colour goes from the multiply state straight to the output state. Scaled colours
// go through one shared 8x8 multiplier and a divide-by-255 stage, a multiply and a
// store state per channel; turn on, blink and rainbow first pass a multiply state
// that picks the sequence, breathe first forms its brightness factor instead. A new
// command is taken only once the last result has been accepted.
// While the receiver stalls the result is held and s_tready stays low.
// Reset sets colour to black, brightness to 16 and the mode to none.
`default_nettype none
module rgb_led_effect_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,  // [7:0] blink_times, [8] repeat_forever, rest zero
	input  wire  [2:0]  s_tuser,  // [2:0] opcode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,  // [7:0] red_out, [15:8] green_out, [23:16] blue_out,
	                              // [25:24] effect_mode, rest zero
	output logic [0:0]  m_tuser,  // [0] pixel_update
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [7:0]  cfg_index,
	input  wire  [7:0]  cfg_data
);

	rgbfx_pkg::cmd_t cmd;
	rgbfx_pkg::sts_t sts;
	logic [7:0]      red, green, blue;
	logic [1:0]      mode;
	logic            upd;

	assign cfg_ready = 1'b1;

	rgbfx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rgbfx_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_valid && cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_opcode         (s_tuser),
		.in_blink_times    (s_tdata[7:0]),
		.in_repeat_forever (s_tdata[8]),
		.cmd               (cmd),
		.sts               (sts),
		.red_out           (red),
		.green_out         (green),
		.blue_out          (blue),
		.pixel_update      (upd),
		.effect_mode       (mode)
	);

	assign m_tdata = {6'b0, mode, blue, green, red};
	assign m_tuser = upd;

endmodule
`default_nettype wire

// ===== tb/sv/rgbfx_tb_pkg.sv =====
`timescale 1ns / 100ps
// Pixel predictor and result checker for the RGB LED effect engine testbench.
package rgbfx_tb_pkg;
	import rgbfx_pkg::*;

	// Opcodes outside the defined set; the engine leaves its state alone for these
	localparam logic [2:0] OP_RSVD_LO = 3'd6;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;
	// Register indexes with nothing behind them
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 8'd4;
	localparam logic [CfgIdxW-1:0] CFG_TOP   = 8'd255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       update;
		mode_t      mode;
	} pixel_t;

	class led_pixel_predictor;
		logic [7:0] base_r, base_g, base_b, bright;
		mode_t      mode;
		logic [8:0] half_periods;
		logic       endless;
		logic [7:0] hue;
		logic       rising;
		logic [7:0] level;
		logic [8:0] cyan;    // [8] active, [7:0] level
		pixel_t     pending_pixels[$];
		int         errors;
		int         checked;

		function new();
			base_r = '0;
			base_g = '0;
			base_b = '0;
			bright = BRIGHT_RESET;
			mode = MODE_NONE;
			half_periods = '0;
			endless = 1'b0;
			hue = '0;
			rising = 1'b1;
			level = '0;
			cyan = '0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [7:0] scale(input logic [7:0] v, input logic [7:0] f);
			logic [15:0] prod;
			logic [15:0] quot;
			prod = v * f;
			quot = prod / 16'd255;
			return quot[7:0];
		endfunction

		function void hue_colour(input logic [7:0] pos, output logic [7:0] r, g, b);
			logic [7:0] p;
			p = CHAN_MAX - pos;
			if (p < WHEEL_THIRD) begin
				r = scale(CHAN_MAX - p * 3, bright);
				g = '0;
				b = scale(p * 3, bright);
			end else if (p < WHEEL_2THIRD) begin
				p = p - WHEEL_THIRD;
				r = '0;
				g = scale(p * 3, bright);
				b = scale(CHAN_MAX - p * 3, bright);
			end else begin
				p = p - WHEEL_2THIRD;
				r = scale(p * 3, bright);
				g = scale(CHAN_MAX - p * 3, bright);
				b = '0;
			end
		endfunction

		function void write_register(input logic [7:0] idx, input logic [7:0] val);
			case (idx)
				CFG_RED: begin
					base_r = val;
					cyan = '0;
				end
				CFG_GREEN: begin
					base_g = val;
					cyan = '0;
				end
				CFG_BLUE: begin
					base_b = val;
					cyan = '0;
				end
				CFG_BRIGHT: bright = val;
				default: ;
			endcase
		endfunction

		// Advance the engine state by one command and queue the pixel it yields
		function void take_command(input logic [2:0] op, input logic [7:0] times,
			input logic rep);
			logic [7:0] cr, cg, cb, r, g, b, s;
			pixel_t px;
			if (cyan[8]) begin
				cr = '0;
				cg = cyan[7:0];
				cb = cyan[7:0];
			end else begin
				cr = base_r;
				cg = base_g;
				cb = base_b;
			end
			r = '0;
			g = '0;
			b = '0;
			px = '0;
			case (op)
				OP_TICK: begin
					case (mode)
						MODE_BLINK: begin
							half_periods = half_periods - 9'd1;
							px.update = 1'b1;
							if (half_periods[0]) begin
								r = scale(cr, bright);
								g = scale(cg, bright);
								b = scale(cb, bright);
							end else if (half_periods == '0 && !endless) begin
								mode = MODE_NONE;
							end
						end
						MODE_RAINBOW: begin
							hue = hue + HUE_STEP;
							hue_colour(hue, r, g, b);
							px.update = 1'b1;
						end
						MODE_BREATHE: begin
							if (rising) begin
								if (level >= BREATHE_TOP) rising = 1'b0;
								else level = level + BREATHE_STEP;
							end else begin
								if (level <= BREATHE_STEP) rising = 1'b1;
								else level = level - BREATHE_STEP;
							end
							s = scale(bright, level);
							r = scale(cr, s);
							g = scale(cg, s);
							b = scale(cb, s);
							px.update = 1'b1;
						end
						default: ;
					endcase
				end
				OP_ON: begin
					mode = MODE_NONE;
					r = scale(cr, bright);
					g = scale(cg, bright);
					b = scale(cb, bright);
					// keep a dim colour visible rather than blank
					if ({cr, cg, cb} != '0 && {r, g, b} == '0 && bright != '0) begin
						r = {7'd0, cr != '0};
						g = {7'd0, cg != '0};
						b = {7'd0, cb != '0};
					end
					px.update = 1'b1;
				end
				OP_OFF: begin
					mode = MODE_NONE;
					px.update = 1'b1;
				end
				OP_BLINK: begin
					mode = MODE_BLINK;
					half_periods = {times, 1'b0};
					endless = rep || times == '0;
				end
				OP_RAINBOW: begin
					mode = MODE_RAINBOW;
					hue = '0;
				end
				OP_BREATHE: begin
					mode = MODE_BREATHE;
					rising = 1'b1;
					level = '0;
					if ({cr, cg, cb} == '0) cyan = {1'b1, bright};
				end
				default: ;
			endcase
			px.red = r;
			px.green = g;
			px.blue = b;
			px.mode = mode;
			pending_pixels.push_back(px);
		endfunction

		task report(input string msg);
			$display("[tb] mismatch at pixel %0d: %s", checked, msg);
			errors++;
		endtask

		task compare_field(input string name, input int got, input int want);
			if (got != want) report($sformatf("%s is %0d, want %0d", name, got, want));
		endtask

		task check_pixel(input pixel_t seen);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				report("pixel with no command outstanding");
			end else begin
				want = pending_pixels.pop_front();
				compare_field("red", seen.red, want.red);
				compare_field("green", seen.green, want.green);
				compare_field("blue", seen.blue, want.blue);
				compare_field("update", seen.update, want.update);
				compare_field("mode", seen.mode, want.mode);
			end
			checked++;
		endtask
	endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top level of the RGB LED effect engine testbench: stimulus, handshakes and verdict.
module tb;
	import rgbfx_pkg::*;
	import rgbfx_tb_pkg::*;

	localparam int CycleLimit  = 400000;
	localparam int TargetItems = 1300;
	localparam int DrainCycles = 16;
	localparam int LongHold    = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	led_pixel_predictor pixels;
	int cycles = 0;
	int items_sent = 0;
	bit no_idle = 1'b0;
	int long_hold = 0;

	rgb_led_effect_engine u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("[rgb_led_effect_engine] ERROR");
			$finish;
		end
	end

	// Observe every transaction at the edge that completes it
	always @(posedge clk) begin : observe
		pixel_t seen;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.red = m_tdata[7:0];
				seen.green = m_tdata[15:8];
				seen.blue = m_tdata[23:16];
				seen.update = m_tuser[0];
				seen.mode = mode_t'(m_tdata[25:24]);
				pixels.check_pixel(seen);
			end
			if (cfg_valid && cfg_ready) pixels.write_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready) pixels.take_command(s_tuser, s_tdata[7:0], s_tdata[8]);
		end
	end

	initial begin : receiver
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold > 0) begin
				stall = long_hold;
				long_hold = 0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 14);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Leave s_tvalid high after the transaction; the next command lowers it if it waits
	task send_command(input logic [2:0] op, input logic [7:0] times, input logic rep);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, rep, times};
		do @(posedge clk); while (!s_tready);
		if (op <= OP_BREATHE) items_sent++;
	endtask

	task send_op(input logic [2:0] op);
		send_command(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task send_ticks(input int n);
		repeat (n) send_op(OP_TICK);
	endtask

	task cfg_write(input logic [7:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drop the command stream and wait until the engine has nothing in flight
	task settle();
		s_tvalid <= 1'b0;
		// let the observer queue a command taken at this edge before looking
		@(posedge clk);
		while (pixels.pending_pixels.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task random_config();
		if ($urandom_range(0, 5) == 0) begin
			// black base colour, so breathe falls back to the cyan override
			cfg_write(CFG_RED, 8'd0);
			cfg_write(CFG_GREEN, 8'd0);
			cfg_write(CFG_BLUE, 8'd0);
		end else begin
			if ($urandom_range(0, 2) != 0) cfg_write(CFG_RED, pick_level());
			if ($urandom_range(0, 2) != 0) cfg_write(CFG_GREEN, pick_level());
			if ($urandom_range(0, 2) != 0) cfg_write(CFG_BLUE, pick_level());
		end
		if ($urandom_range(0, 2) != 0) cfg_write(CFG_BRIGHT, pick_level());
		if ($urandom_range(0, 7) == 0)
			cfg_write(8'($urandom_range(CFG_SPARE, CFG_TOP)), pick_level());
		cfg_valid <= 1'b0;
	endtask

	task run_effect();
		logic [7:0] times;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				send_op(OP_BREATHE);
				// long runs reach the turning point at the top, the longest also the one at the bottom
				send_ticks(($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
					: $urandom_range(1, 25));
			end
			3, 4: begin
				times = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 6));
				send_command(OP_BLINK, times, $urandom_range(0, 3) == 0);
				send_ticks($urandom_range(1, 20));
			end
			5, 6: begin
				send_op(OP_RAINBOW);
				send_ticks($urandom_range(1, 70));
			end
			7: send_op(($urandom_range(0, 1) != 0) ? OP_ON : OP_OFF);
			default: repeat ($urandom_range(1, 6)) send_op(3'($urandom_range(0, 7)));
		endcase
	endtask

	initial begin : stimulus
		int phase;
		int phase_start;
		int phase_len;
		pixels = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset colour is black: breathe latches cyan at the reset brightness
		send_op(OP_ON);
		send_op(OP_TICK);
		send_op(OP_BREATHE);
		send_op(OP_TICK);
		send_op(OP_ON);
		send_command(OP_RSVD_LO, 8'd0, 1'b0);
		send_command(OP_RSVD_HI, 8'd255, 1'b1);
		send_op(OP_OFF);
		settle();

		cfg_write(CFG_RED, 8'd255);
		cfg_write(CFG_GREEN, 8'd255);
		cfg_write(CFG_BLUE, 8'd255);
		cfg_write(CFG_BRIGHT, 8'd255);
		cfg_write(CFG_SPARE, 8'd0);
		cfg_write(CFG_TOP, 8'd0);
		cfg_valid <= 1'b0;
		send_op(OP_ON);
		send_op(OP_RAINBOW);
		send_ticks(2);
		send_command(OP_BLINK, 8'd1, 1'b0);
		send_ticks(3);
		settle();

		// Dim colour: turn on must keep the nonzero channels at one
		cfg_write(CFG_RED, 8'd1);
		cfg_write(CFG_GREEN, 8'd0);
		cfg_write(CFG_BLUE, 8'd2);
		cfg_write(CFG_BRIGHT, 8'd1);
		cfg_valid <= 1'b0;
		send_op(OP_ON);
		send_command(OP_BLINK, 8'd0, 1'b0);
		send_ticks(2);
		send_command(OP_BLINK, 8'd255, 1'b1);
		send_op(OP_TICK);
		settle();

		cfg_write(CFG_BRIGHT, 8'd0);
		cfg_valid <= 1'b0;
		send_op(OP_ON);
		send_op(OP_BREATHE);
		send_op(OP_TICK);

		phase = 0;
		while (items_sent < TargetItems) begin
			phase++;
			settle();
			no_idle = ($urandom_range(0, 4) == 0);
			if (phase == 3) long_hold = LongHold;
			random_config();
			phase_start = items_sent;
			phase_len = $urandom_range(30, 80);
			while (items_sent - phase_start < phase_len) run_effect();
		end
		settle();

		if (pixels.errors == 0 && pixels.pending_pixels.size() == 0) begin
			$display("[rgb_led_effect_engine] OK");
		end else begin
			$display("[rgb_led_effect_engine] ERROR");
		end
		$finish;
	end

endmodule

// ===== rgb_led_effect_engine.f =====
rtl/rgbfx_pkg.sv
rtl/rgbfx_ctrl.sv
rtl/rgbfx_dp.sv
rtl/rgb_led_effect_engine.sv
tb/sv/rgbfx_tb_pkg.sv
tb/sv/tb.sv
